[hw/rtl/rcsdt_pkg.sv]
package rcsdt_pkg;

	// channel count limits
	localparam int MAX_CH       = 8;
	localparam int CHANNELS_DEF = 8;

	// field widths
	localparam int READ_W    = 16;
	localparam int PINS_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	typedef logic [READ_W-1:0] reading_t;
	typedef logic [PINS_W-1:0] pins_t;

	// register reset values
	localparam reading_t RESET_PERIOD  = 16'd40000;
	localparam reading_t RESET_CHARGE  = 16'd2000;
	localparam reading_t RESET_TIMEOUT = 16'd40000;
	localparam reading_t EMPTY_READING = 16'hFFFF;
	localparam pins_t    ALL_PINS      = 8'hFF;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_PERIOD = 2'd0,
		CFG_CHARGE_TICKS = 2'd1,
		CFG_TIMEOUT      = 2'd2,
		CFG_EMITTER_ON   = 2'd3
	} cfg_idx_t;

	// one result item
	typedef struct packed {
		logic                   charge_drive;
		logic                   emitter_power;
		logic                   frame_valid;
		reading_t [MAX_CH-1:0]  times;
	} result_t;

endpackage

[hw/rtl/rcsdt_if.sv]
// pin sample channel
interface rcsdt_in_if import rcsdt_pkg::*; ();
	logic  valid;
	logic  ready;
	pins_t pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink   (input valid, input pin_levels, output ready);
endinterface

// frame reading channel
interface rcsdt_out_if import rcsdt_pkg::*; ();
	logic     valid;
	logic     ready;
	logic     charge_drive;
	logic     emitter_power;
	logic     frame_valid;
	reading_t time_ch0;
	reading_t time_ch1;
	reading_t time_ch2;
	reading_t time_ch3;
	reading_t time_ch4;
	reading_t time_ch5;
	reading_t time_ch6;
	reading_t time_ch7;

	modport source (
		output valid, output charge_drive, output emitter_power, output frame_valid,
		output time_ch0, output time_ch1, output time_ch2, output time_ch3,
		output time_ch4, output time_ch5, output time_ch6, output time_ch7,
		input ready
	);
	modport sink (
		input valid, input charge_drive, input emitter_power, input frame_valid,
		input time_ch0, input time_ch1, input time_ch2, input time_ch3,
		input time_ch4, input time_ch5, input time_ch6, input time_ch7,
		output ready
	);
endinterface

[hw/rtl/rc_sensor_discharge_timer.sv]
// RC reflectance sensor discharge timer.
// in_ch carries one item per prescaled timer tick: the sampled levels of the
// sensor pins. Each accepted item advances the frame counter by one (clearing
// it at frame end) and gives exactly one item on out_ch: the charge drive level
// for that tick, the emitter power level, and frame_valid. On the tick the
// counter reaches or passes frame_period the eight discharge readings are given
// with frame_valid high; on other ticks they read zero. The readings are then
// cleared and charging starts again. Configuration is to be written through
// cfg_we / cfg_index / cfg_wdata only while idle; the block does not enforce it.
// Throughput: one item per cycle while the skid register is empty; the edge
// capture and frame logic settle in one pass from state to output registers.
// Stall: an output register plus a one-entry skid register sit before out_ch,
// so one more item is taken while a result waits; in_ch.ready drops only
// when both are full and returns as soon as out_ch takes an item.
// Reset: counter zero, all channels pending, readings 65535, registers at
// their defaults (period 40000, charge 2000, timeout 40000, emitter on).
module rc_sensor_discharge_timer import rcsdt_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rcsdt_in_if.sink             in_ch,
	rcsdt_out_if.source          out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam pins_t ACT_MASK = pins_t'((9'd1 << CHANNELS) - 9'd1);

	// configuration registers
	reading_t frame_period_q;
	reading_t charge_ticks_q;
	reading_t timeout_q;
	logic     emitter_on_q;

	// frame state
	reading_t frame_count_q;
	pins_t    pending_q;
	pins_t    last_pins_q;
	reading_t cap_q [CHANNELS];

	// output buffering
	result_t out_q;
	result_t skid_q;
	logic    out_v_q;
	logic    skid_v_q;

	logic     accept;
	logic     pop;
	pins_t    pins;
	pins_t    fell;
	pins_t    changed;
	pins_t    pend_after;
	logic     charging;
	logic     capture;
	logic     done;
	reading_t cap_next [CHANNELS];
	result_t  res;

	assign in_ch.ready = !skid_v_q;
	assign accept      = in_ch.valid && !skid_v_q;
	assign pop         = out_v_q && out_ch.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_period_q <= RESET_PERIOD;
			charge_ticks_q <= RESET_CHARGE;
			timeout_q      <= RESET_TIMEOUT;
			emitter_on_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_PERIOD: frame_period_q <= cfg_wdata;
				CFG_CHARGE_TICKS: charge_ticks_q <= cfg_wdata;
				CFG_TIMEOUT:      timeout_q      <= cfg_wdata;
				CFG_EMITTER_ON:   emitter_on_q   <= cfg_wdata[0];
			endcase
		end
	end

	// edge detect and capture decision
	always_comb begin
		pins       = in_ch.pin_levels & ACT_MASK;
		charging   = frame_count_q < charge_ticks_q;
		fell       = last_pins_q & ~pins & ACT_MASK;
		capture    = !charging && (fell != '0);
		changed    = ~pins & pending_q & ACT_MASK;
		pend_after = capture ? pins : pending_q;
		done       = frame_count_q >= frame_period_q;
	end

	// per-channel capture and result assembly
	always_comb begin
		res               = '0;
		res.charge_drive  = charging;
		res.emitter_power = emitter_on_q;
		res.frame_valid   = done;
		for (int i = 0; i < CHANNELS; i++) begin
			cap_next[i] = (capture && changed[i]) ? frame_count_q : cap_q[i];
		end
		if (done) begin
			for (int i = 0; i < MAX_CH; i++) begin
				res.times[i] = EMPTY_READING;
			end
			for (int i = 0; i < CHANNELS; i++) begin
				res.times[i] = pend_after[i] ? timeout_q : cap_next[i];
			end
		end
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			pending_q     <= ACT_MASK;
			last_pins_q   <= ALL_PINS;
			for (int i = 0; i < CHANNELS; i++) begin
				cap_q[i] <= EMPTY_READING;
			end
		end else if (accept) begin
			last_pins_q <= pins;
			if (done) begin
				frame_count_q <= '0;
				pending_q     <= ACT_MASK;
				for (int i = 0; i < CHANNELS; i++) begin
					cap_q[i] <= EMPTY_READING;
				end
			end else begin
				frame_count_q <= frame_count_q + 16'd1;
				pending_q     <= pend_after;
				for (int i = 0; i < CHANNELS; i++) begin
					cap_q[i] <= cap_next[i];
				end
			end
		end
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept;
			end
		end else if (accept) begin
			if (!out_v_q) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			if (!out_v_q) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_ch.valid         = out_v_q;
	assign out_ch.charge_drive  = out_q.charge_drive;
	assign out_ch.emitter_power = out_q.emitter_power;
	assign out_ch.frame_valid   = out_q.frame_valid;
	assign out_ch.time_ch0      = out_q.times[0];
	assign out_ch.time_ch1      = out_q.times[1];
	assign out_ch.time_ch2      = out_q.times[2];
	assign out_ch.time_ch3      = out_q.times[3];
	assign out_ch.time_ch4      = out_q.times[4];
	assign out_ch.time_ch5      = out_q.times[5];
	assign out_ch.time_ch6      = out_q.times[6];
	assign out_ch.time_ch7      = out_q.times[7];

endmodule

[hw/rtl/rcsdt_checker.sv]
module rcsdt_checker import rcsdt_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input logic     frame_valid,
	input reading_t time_ch0,
	input reading_t time_ch7
);

	// a stalled item holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_valid) && $stable(time_ch0))
		else $error("stalled output item changed");

	// readings are zero outside frame completion
	a_zero_readings: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_valid |-> time_ch0 == '0 && time_ch7 == '0)
		else $error("nonzero reading without frame_valid");

	// input blocks only behind a held output item
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input blocked with empty output");

	// an item taken behind a stalled output fills the skid entry
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && in_valid && in_ready |=> !in_ready)
		else $error("skid entry not marked full");

endmodule

bind rc_sensor_discharge_timer rcsdt_checker u_rcsdt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.frame_valid(out_ch.frame_valid),
	.time_ch0   (out_ch.time_ch0),
	.time_ch7   (out_ch.time_ch7)
);

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import rcsdt_pkg::*;

	localparam int    NCH         = CHANNELS_DEF;
	localparam pins_t CHAN_MASK   = pins_t'((1 << NCH) - 1);
	localparam int    HOLD_CYCLES = 40;
	localparam int    STALL_LIMIT = 1000;
	localparam int    RAND_PHASES = 8;
	localparam int    PHASE_ITEMS = 50;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	rcsdt_in_if  in_ch ();
	rcsdt_out_if out_ch ();

	rc_sensor_discharge_timer #(.CHANNELS(NCH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// pin samples waiting to be sent and tick reports waiting to come back
	pins_t   pin_samples[$];
	result_t tick_reports[$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_requests;
	int unsigned hold_served;
	int unsigned hold_left;
	int unsigned mismatches;
	int unsigned samples_sent;
	int unsigned reports_seen;
	int unsigned frames_seen;
	int unsigned quiet_cycles;
	pins_t       gen_pins;

	// shadow registers and discharge timer state
	reading_t cur_period;
	reading_t cur_charge;
	reading_t cur_timeout;
	logic     cur_emitter;
	reading_t sim_count;
	pins_t    sim_pending;
	pins_t    sim_last;
	reading_t sim_reading [MAX_CH];

	function automatic void clear_readings();
		for (int i = 0; i < MAX_CH; i++)
			sim_reading[i] = EMPTY_READING;
		sim_pending = CHAN_MASK;
	endfunction

	// one timer tick: edge capture, then frame completion
	function automatic result_t predict_tick(pins_t raw);
		result_t  r;
		pins_t    pins;
		pins_t    fell;
		pins_t    caught;
		reading_t c;
		logic     charging;

		pins     = raw & CHAN_MASK;
		c        = sim_count;
		charging = c < cur_charge;
		fell     = sim_last & ~pins & CHAN_MASK;
		if (!charging && fell != '0) begin
			caught = ~pins & sim_pending & CHAN_MASK;
			for (int i = 0; i < MAX_CH; i++)
				if (caught[i])
					sim_reading[i] = c;
			sim_pending = pins;
		end
		sim_last = pins;

		r = '0;
		r.charge_drive  = charging;
		r.emitter_power = cur_emitter;
		if (c >= cur_period) begin
			for (int i = 0; i < MAX_CH; i++)
				if (sim_pending[i] && CHAN_MASK[i])
					sim_reading[i] = cur_timeout;
			r.frame_valid = 1'b1;
			for (int i = 0; i < MAX_CH; i++)
				r.times[i] = sim_reading[i];
			clear_readings();
			sim_count = '0;
		end else begin
			sim_count = c + 1'b1;
		end
		return r;
	endfunction

	// mostly discharging pins with recharges, some noise
	function automatic pins_t next_pins();
		int unsigned roll;

		roll = $urandom_range(99);
		if (roll < 10)
			gen_pins = pins_t'($urandom);
		else if (roll < 22)
			gen_pins = ALL_PINS;
		else if (roll < 60)
			gen_pins[$urandom_range(PINS_W - 1)] = 1'b0;
		return gen_pins;
	endfunction

	function automatic void check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		end
	endfunction

	// sender side
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				tick_reports.push_back(predict_tick(in_ch.pin_levels));
				samples_sent++;
			end
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (pin_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_ch.valid      <= 1'b1;
					in_ch.pin_levels <= pin_samples.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver side: compare each item, then pick next ready
	always @(posedge clk) begin
		result_t want;

		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				reports_seen++;
				if (out_ch.frame_valid)
					frames_seen++;
				if (tick_reports.size() == 0) begin
					mismatches++;
					$display("%0t: result item with nothing expected", $time);
				end else begin
					want = tick_reports.pop_front();
					check_field("charge_drive", want.charge_drive, out_ch.charge_drive);
					check_field("emitter_power", want.emitter_power, out_ch.emitter_power);
					check_field("frame_valid", want.frame_valid, out_ch.frame_valid);
					check_field("time_ch0", want.times[0], out_ch.time_ch0);
					check_field("time_ch1", want.times[1], out_ch.time_ch1);
					check_field("time_ch2", want.times[2], out_ch.time_ch2);
					check_field("time_ch3", want.times[3], out_ch.time_ch3);
					check_field("time_ch4", want.times[4], out_ch.time_ch4);
					check_field("time_ch5", want.times[5], out_ch.time_ch5);
					check_field("time_ch6", want.times[6], out_ch.time_ch6);
					check_field("time_ch7", want.times[7], out_ch.time_ch7);
				end
			end
			if (hold_left == 0 && hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pin_samples.size() != 0 || in_ch.valid || tick_reports.size() != 0);
	endtask

	task automatic write_reg(cfg_idx_t idx, reading_t val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FRAME_PERIOD: cur_period  = val;
			CFG_CHARGE_TICKS: cur_charge  = val;
			CFG_TIMEOUT:      cur_timeout = val;
			CFG_EMITTER_ON:   cur_emitter = val[0];
			default: ;
		endcase
	endtask

	task automatic write_all(reading_t period, reading_t charge, reading_t timeout, logic emit);
		wait_drained();
		write_reg(CFG_FRAME_PERIOD, period);
		write_reg(CFG_CHARGE_TICKS, charge);
		write_reg(CFG_TIMEOUT, timeout);
		write_reg(CFG_EMITTER_ON, reading_t'(emit));
	endtask

	task automatic queue_pins(pins_t p);
		pin_samples.push_back(p);
	endtask

	initial begin
		reading_t period;
		reading_t charge;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_wdata        = '0;
		in_ch.valid      = 1'b0;
		in_ch.pin_levels = '0;
		out_ch.ready     = 1'b0;
		send_idle_pct    = 16;
		recv_idle_pct    = 51;
		gen_pins         = ALL_PINS;

		cur_period  = RESET_PERIOD;
		cur_charge  = RESET_CHARGE;
		cur_timeout = RESET_TIMEOUT;
		cur_emitter = 1'b1;
		sim_count   = '0;
		sim_last    = ALL_PINS;
		clear_readings();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// short frame: edge while charging, staged discharge, edge on the last tick
		write_all(16'd6, 16'd2, 16'd0, 1'b0);
		queue_pins(8'h00);
		queue_pins(8'hFF);
		queue_pins(8'hFF);
		queue_pins(8'h0F);
		queue_pins(8'h0E);
		queue_pins(8'hFE);
		queue_pins(8'h0C);

		// charge longer than the period: every channel times out
		write_all(16'd3, 16'hFFFF, 16'hFFFF, 1'b1);
		queue_pins(8'h00);
		queue_pins(8'hFF);
		queue_pins(8'h00);
		queue_pins(8'h55);

		// longest period, then the period drops below the running count
		wait_drained();
		write_reg(CFG_FRAME_PERIOD, 16'hFFFF);
		write_reg(CFG_CHARGE_TICKS, 16'd1);
		queue_pins(8'hFF);
		queue_pins(8'hFF);
		queue_pins(8'h7F);
		queue_pins(8'h3F);
		queue_pins(8'h3F);
		queue_pins(8'h00);
		wait_drained();
		write_reg(CFG_FRAME_PERIOD, 16'd1);
		queue_pins(8'hFF);
		queue_pins(8'h0F);
		queue_pins(8'h0E);

		// random phases with fresh settings each time
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 3) begin
				send_idle_pct = 51;
				recv_idle_pct = 16;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 4) begin
				period = 16'hFFFF;
				charge = reading_t'($urandom_range(20, 1));
			end else begin
				period = ($urandom_range(9) == 0) ? 16'd1 : reading_t'($urandom_range(40, 2));
				if ($urandom_range(99) < 15)
					charge = reading_t'($urandom_range(16'hFFFF, period + 1));
				else
					charge = reading_t'($urandom_range(period, 1));
			end
			write_all(period, charge, reading_t'($urandom), 1'($urandom_range(1)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				queue_pins(next_pins());
				// sender stops halfway until the block has drained
				if (ph == 2 && n == PHASE_ITEMS / 2)
					wait_drained();
			end
			// long receiver hold while samples keep coming
			if (ph == 1)
				hold_requests++;
		end

		wait_drained();
		repeat (8) @(posedge clk);

		$display("%0d pin samples sent, %0d tick reports checked, %0d frames completed",
			samples_sent, reports_seen, frames_seen);
		$display("%0d random settings plus directed frames, with stalls and a long hold",
			RAND_PHASES);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		hold_requests = 0;
		hold_served   = 0;
		hold_left     = 0;
		mismatches    = 0;
		samples_sent  = 0;
		reports_seen  = 0;
		frames_seen   = 0;
		quiet_cycles  = 0;
	end

endmodule

[files.f]
hw/rtl/rcsdt_pkg.sv
hw/rtl/rcsdt_if.sv
hw/rtl/rc_sensor_discharge_timer.sv
hw/rtl/rcsdt_checker.sv
verif/testbench.sv
